// ----- rtl/tdvc_pkg.sv -----
// Package for the 2D valid convolution core: shared constants.
// No dependencies.
`default_nettype none
package tdvc_pkg;
  localparam int unsigned MAX_IMAGE   = 64;
  localparam int unsigned MAX_KERNEL  = 7;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned VALUE_BITS = 38;
  localparam int unsigned POS_BITS   = 6;
  localparam logic        FUNC_WEIGHT = 1'b0;
  localparam logic        FUNC_PIXEL  = 1'b1;
  localparam logic [0:0]  REG_IMAGE_SIZE  = 1'b0;
  localparam logic [0:0]  REG_KERNEL_SIZE = 1'b1;
endpackage
`default_nettype wire

// ----- rtl/tdvc_if.sv -----
// Valid/ready channel interfaces for the convolution core.
// Depends on tdvc_pkg for the payload widths.
`default_nettype none
interface tdvc_in_if;
  logic valid;
  logic ready;
  logic func;
  logic [2:0] weight_row;
  logic [2:0] weight_col;
  logic signed [tdvc_pkg::SAMPLE_BITS-1:0] weight;
  logic signed [tdvc_pkg::SAMPLE_BITS-1:0] pixel;
  modport source(output valid, func, weight_row, weight_col, weight, pixel, input ready);
  modport sink(input valid, func, weight_row, weight_col, weight, pixel, output ready);
  modport monitor(input valid, ready, func, weight_row, weight_col, weight, pixel);
endinterface

interface tdvc_out_if;
  logic valid;
  logic ready;
  logic signed [tdvc_pkg::VALUE_BITS-1:0] conv_value;
  logic [tdvc_pkg::POS_BITS-1:0] out_row;
  logic [tdvc_pkg::POS_BITS-1:0] out_col;
  logic last;
  modport source(output valid, conv_value, out_row, out_col, last, input ready);
  modport sink(input valid, conv_value, out_row, out_col, last, output ready);
  modport monitor(input valid, ready, conv_value, out_row, out_col, last);
endinterface

interface tdvc_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [6:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
  modport monitor(input valid, ready, index, data);
endinterface
`default_nettype wire

// ----- rtl/two_d_valid_convolution_core.sv -----
// 2D valid convolution, stride 1. Depends on tdvc_pkg and tdvc_if.
// Throughput: one item per cycle while the output is not stalled. A pixel's result passes through the stage registers.
// The line buffer is one synchronous memory, one entry per image column
// holding that column's last MAX_KERNEL pixels; one read and one write back
// per cycle. Reset: weights zero, raster position zero, image_size 28,
// kernel_size 3; line memory is not cleared (only rows written this frame are read).
`default_nettype none
module two_d_valid_convolution_core (
  input wire logic clk,
  input wire logic rst,
  tdvc_in_if.sink   in_ch,
  tdvc_out_if.source out_ch,
  tdvc_cfg_if.sink  cfg
);
  localparam int MAX_IMAGE   = tdvc_pkg::MAX_IMAGE;
  localparam int MAX_KERNEL  = tdvc_pkg::MAX_KERNEL;
  localparam int SAMPLE_BITS = tdvc_pkg::SAMPLE_BITS;
  localparam int CW = (MAX_IMAGE > 1) ? $clog2(MAX_IMAGE) : 1;
  localparam int KW = $clog2(MAX_KERNEL + 1);
  localparam int PW = 2 * SAMPLE_BITS;
  localparam int VB = tdvc_pkg::VALUE_BITS;
  localparam int POS_BITS_L = tdvc_pkg::POS_BITS;

  logic [6:0] image_size;
  logic [2:0] kernel_size;
  logic [CW:0] n_eff;
  logic [KW-1:0] k_eff;
  logic [CW:0] row_count, col_count;

  // Window registers: last MAX_KERNEL columns of each kernel row.
  logic signed [SAMPLE_BITS-1:0] win [MAX_KERNEL][MAX_KERNEL];
  logic signed [SAMPLE_BITS-1:0] kern [MAX_KERNEL][MAX_KERNEL];
  // Line memory: one column entry holds the last MAX_KERNEL rows of it.
  logic [SAMPLE_BITS*MAX_KERNEL-1:0] line_mem [MAX_IMAGE];
  logic [SAMPLE_BITS*MAX_KERNEL-1:0] col_rd;
  logic [SAMPLE_BITS*MAX_KERNEL-1:0] new_col;
  logic fwd;
  logic [CW:0] s1_c;

  // Stage registers
  logic s1_v, s1_emit, s1_last;
  logic [CW:0] s1_r0, s1_c0;
  logic signed [SAMPLE_BITS-1:0] s1_pix;
  logic s2_v, s2_last;
  logic [POS_BITS_L-1:0] s2_r0, s2_c0;
  logic signed [PW+1:0] s2_part [MAX_KERNEL];
  logic s3_v;
  logic s3_last;
  logic [POS_BITS_L-1:0] s3_r0, s3_c0;
  logic signed [VB-1:0] s3_sum;

  logic stall, in_acc, pix_acc, cfg_acc;
  assign stall   = s3_v && !out_ch.ready;
  assign in_ch.ready = !stall;
  assign cfg.ready = 1'b1;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign pix_acc = in_acc && (in_ch.func == tdvc_pkg::FUNC_PIXEL);
  assign cfg_acc = cfg.valid && cfg.ready;

  // Effective sizes
  always_comb begin
    if (image_size == 7'd0) n_eff = (CW+1)'(1);
    else if (32'(image_size) > MAX_IMAGE) n_eff = (CW+1)'(MAX_IMAGE);
    else n_eff = (CW+1)'(image_size);
    if (kernel_size == 3'd0) k_eff = KW'(1);
    else if (32'(kernel_size) > MAX_KERNEL) k_eff = KW'(MAX_KERNEL);
    else k_eff = KW'(kernel_size);
  end

  // Raster position of this pixel
  logic [CW:0] r, c;
  logic eof, emit;
  always_comb begin
    r = row_count;
    c = col_count;
    if (r >= n_eff || c >= n_eff) begin
      r = '0;
      c = '0;
    end
    eof  = (r == n_eff - 1'b1) && (c == n_eff - 1'b1);
    emit = !((CW+1)'(k_eff) > n_eff) && (r + 1'b1 >= (CW+1)'(k_eff))
           && (c + 1'b1 >= (CW+1)'(k_eff));
  end

  // Config and raster control
  always_ff @(posedge clk) begin
    if (rst) begin
      image_size  <= 7'd28;
      kernel_size <= 3'd3;
      row_count   <= '0;
      col_count   <= '0;
    end else if (cfg_acc) begin
      if (cfg.index == tdvc_pkg::REG_IMAGE_SIZE) image_size <= cfg.data;
      else kernel_size <= cfg.data[2:0];
      row_count <= '0;
      col_count <= '0;
    end else if (pix_acc) begin
      if (c + 1'b1 >= n_eff) begin
        col_count <= '0;
        row_count <= eof ? '0 : r + 1'b1;
      end else begin
        col_count <= c + 1'b1;
        row_count <= r;
      end
    end
  end

  // Kernel weights at (row, col); the product stage aligns the window's
  // newest k rows and columns to them.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_KERNEL; i++)
        for (int j = 0; j < MAX_KERNEL; j++) kern[i][j] <= '0;
    end else if (in_acc && in_ch.func == tdvc_pkg::FUNC_WEIGHT
                 && 32'(in_ch.weight_row) < MAX_KERNEL
                 && 32'(in_ch.weight_col) < MAX_KERNEL) begin
      kern[in_ch.weight_row][in_ch.weight_col] <= in_ch.weight;
    end
  end

  // Same-column back-to-back cannot occur unless image width is 1;
  // then forward the column being written back this cycle.
  assign fwd = s1_v && pix_acc && (s1_c == c);

  // Stage 1: read column history; history shifts rows down per column
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (!stall) s1_v <= pix_acc;
    if (pix_acc) begin
      col_rd  <= fwd ? new_col : line_mem[c[CW-1:0]];
      s1_c    <= c;
      s1_pix  <= in_ch.pixel;
      s1_emit <= emit;
      s1_last <= eof;
      s1_r0   <= r + 1'b1 - (CW+1)'(k_eff);
      s1_c0   <= c + 1'b1 - (CW+1)'(k_eff);
    end
  end

  // New column: older rows shift down, last row is the new pixel.
  assign new_col = {s1_pix, col_rd[SAMPLE_BITS*MAX_KERNEL-1:SAMPLE_BITS]};

  // Column write back
  always_ff @(posedge clk) begin
    if (s1_v) line_mem[s1_c[CW-1:0]] <= new_col;
  end

  // Window shift (window row i = oldest..newest)
  always_ff @(posedge clk) begin
    if (s1_v && !stall) begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
        for (int j = 0; j < MAX_KERNEL - 1; j++) win[i][j] <= win[i][j+1];
        win[i][MAX_KERNEL-1] <= new_col[SAMPLE_BITS*i +: SAMPLE_BITS];
      end
    end
  end
  // Combinational window including the current column
  logic signed [SAMPLE_BITS-1:0] wcur [MAX_KERNEL][MAX_KERNEL];
  always_comb begin
    for (int i = 0; i < MAX_KERNEL; i++) begin
      for (int j = 0; j < MAX_KERNEL - 1; j++) wcur[i][j] = win[i][j+1];
      wcur[i][MAX_KERNEL-1] = new_col[SAMPLE_BITS*i +: SAMPLE_BITS];
    end
  end

  // Stage 2: one row of products per lane, aligned to kernel size
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (!stall) s2_v <= s1_v && s1_emit;
    if (!stall) begin
      for (int ki = 0; ki < MAX_KERNEL; ki++) begin
        logic signed [PW+1:0] acc;
        acc = '0;
        for (int kj = 0; kj < MAX_KERNEL; kj++)
          if (ki < int'(k_eff) && kj < int'(k_eff))
            acc += (PW+2)'(wcur[MAX_KERNEL-int'(k_eff)+ki]
                               [MAX_KERNEL-int'(k_eff)+kj] * kern[ki][kj]);
        s2_part[ki] <= acc;
      end
      s2_last <= s1_last;
      s2_r0 <= POS_BITS_L'(s1_r0);
      s2_c0 <= POS_BITS_L'(s1_c0);
    end
  end

  // Stage 3: sum of row partials into output register
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (!stall) s3_v <= s2_v;
    if (!stall) begin
      logic signed [VB-1:0] tot;
      tot = '0;
      for (int ki = 0; ki < MAX_KERNEL; ki++) tot += VB'(s2_part[ki]);
      s3_sum  <= tot;
      s3_last <= s2_last;
      s3_r0   <= s2_r0;
      s3_c0   <= s2_c0;
    end
  end

  assign out_ch.valid      = s3_v;
  assign out_ch.conv_value = s3_sum;
  assign out_ch.out_row    = s3_r0;
  assign out_ch.out_col    = s3_c0;
  assign out_ch.last       = s3_last;
endmodule
`default_nettype wire
